/* rtl/wtpsm_pkg.sv */
// ----------------------------------------------------------------------------
// wtpsm_pkg
// Shared types and constants for the two-part wildcard string matcher.
// ----------------------------------------------------------------------------
package wtpsm_pkg;

  localparam int PATTERN_BYTES = 8;
  localparam int MAX_TEXT      = 65536;

  localparam int BYTE_W    = 8;
  localparam int PAT_W     = 64;
  localparam int LEN_W     = 4;
  localparam int IDX_W     = 16;
  localparam int POS_W     = $clog2(MAX_TEXT + 2);
  localparam int WIN_IDX_W = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_Q_PATTERN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Q_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_R_PATTERN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_R_LENGTH  = 2'd3;

  typedef logic [PATTERN_BYTES-1:0][BYTE_W-1:0] window_t;

  typedef struct packed {
    logic [PAT_W-1:0] q_pattern;
    logic [LEN_W-1:0] q_length;
    logic [PAT_W-1:0] r_pattern;
    logic [LEN_W-1:0] r_length;
  } cfg_t;

  // per-text stream context, kept in the context RAM
  typedef struct packed {
    window_t          window;
    logic [POS_W-1:0] pos;
    logic             first_seen;
    logic [IDX_W-1:0] first_start;
    logic             second_seen;
    logic [IDX_W-1:0] second_start;
  } ctx_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
    logic             too_long;
  } res_t;

endpackage

/* rtl/wtpsm_scan.sv */
// ----------------------------------------------------------------------------
// wtpsm_scan
// Context update for one text byte: window shift, Q and R window checks,
// first- and second-start tracking and the end-of-text result.
// ----------------------------------------------------------------------------
module wtpsm_scan (
  input  wtpsm_pkg::ctx_t                   ctx_i,
  input  wtpsm_pkg::cfg_t                   cfg_i,
  input  logic [wtpsm_pkg::BYTE_W-1:0]      text_byte_i,
  input  logic                              last_byte_i,
  output wtpsm_pkg::ctx_t                   ctx_o,
  output wtpsm_pkg::res_t                   res_o
);

  // does a pattern of len bytes end d places before the newest byte
  function automatic logic holds(wtpsm_pkg::window_t w,
                                 logic [wtpsm_pkg::PAT_W-1:0] pat,
                                 logic [wtpsm_pkg::LEN_W-1:0] len,
                                 logic [wtpsm_pkg::LEN_W-1:0] d);
    logic                                ok;
    logic [wtpsm_pkg::LEN_W:0]           sel;
    ok = (len != '0) &&
         (({1'b0, d} + {1'b0, len}) <= (wtpsm_pkg::LEN_W + 1)'(wtpsm_pkg::PATTERN_BYTES));
    for (int k = 0; k < wtpsm_pkg::PATTERN_BYTES; k++) begin
      sel = {1'b0, d} + {1'b0, len} - (wtpsm_pkg::LEN_W + 1)'(1)
            - (wtpsm_pkg::LEN_W + 1)'(k);
      if (ok && (wtpsm_pkg::LEN_W'(k) < len)) begin
        if (w[sel[wtpsm_pkg::WIN_IDX_W-1:0]] != pat[wtpsm_pkg::BYTE_W*k +: wtpsm_pkg::BYTE_W])
          ok = 1'b0;
      end
    end
    return ok;
  endfunction

  localparam logic [wtpsm_pkg::LEN_W-1:0] MaxLen = wtpsm_pkg::LEN_W'(wtpsm_pkg::PATTERN_BYTES);

  logic [wtpsm_pkg::LEN_W-1:0] ql;
  logic [wtpsm_pkg::LEN_W-1:0] rl;
  logic [wtpsm_pkg::LEN_W-1:0] inner_span;
  logic [wtpsm_pkg::POS_W-1:0] pos_inc;
  logic [wtpsm_pkg::POS_W-1:0] r_start;
  logic                        in_range;
  logic                        q_hit;
  logic                        r_hit;
  logic                        inner_hit;
  logic [wtpsm_pkg::IDX_W-1:0] inner_start;
  logic                        overflow;
  wtpsm_pkg::window_t          win;
  wtpsm_pkg::ctx_t             nxt;

  assign ql         = (cfg_i.q_length > MaxLen) ? MaxLen : cfg_i.q_length;
  assign rl         = (cfg_i.r_length > MaxLen) ? MaxLen : cfg_i.r_length;
  assign inner_span = ql - rl;
  assign pos_inc    = ctx_i.pos + wtpsm_pkg::POS_W'(1);
  assign r_start    = pos_inc - wtpsm_pkg::POS_W'(rl);
  assign in_range   = ctx_i.pos < wtpsm_pkg::POS_W'(wtpsm_pkg::MAX_TEXT);

  always_comb begin
    win[0] = text_byte_i;
    for (int i = 1; i < wtpsm_pkg::PATTERN_BYTES; i++) begin
      win[i] = ctx_i.window[i-1];
    end
  end

  assign q_hit = (ql != '0) && (pos_inc >= wtpsm_pkg::POS_W'(ql)) &&
                 holds(win, cfg_i.q_pattern, ql, '0);
  assign r_hit = (rl != '0) && (pos_inc >= wtpsm_pkg::POS_W'(rl)) &&
                 holds(win, cfg_i.r_pattern, rl, '0);

  // R windows inside Q's match; the earliest start (largest offset) wins
  always_comb begin
    inner_hit   = 1'b0;
    inner_start = '0;
    for (int d = 1; d < wtpsm_pkg::PATTERN_BYTES; d++) begin
      if ((wtpsm_pkg::LEN_W'(d) <= inner_span) &&
          holds(win, cfg_i.r_pattern, rl, wtpsm_pkg::LEN_W'(d))) begin
        inner_hit   = 1'b1;
        inner_start = wtpsm_pkg::IDX_W'(pos_inc - wtpsm_pkg::POS_W'(d)
                                        - wtpsm_pkg::POS_W'(rl));
      end
    end
  end

  always_comb begin
    nxt = ctx_i;
    if (in_range) begin
      nxt.window = win;
      nxt.pos    = pos_inc;
      if (!ctx_i.first_seen && q_hit) begin
        nxt.first_seen  = 1'b1;
        nxt.first_start = wtpsm_pkg::IDX_W'(pos_inc - wtpsm_pkg::POS_W'(ql));
        if ((rl != '0) && (rl < ql) && !ctx_i.second_seen && inner_hit) begin
          nxt.second_seen  = 1'b1;
          nxt.second_start = inner_start;
        end
      end
      if (!nxt.second_seen && r_hit &&
          ((ql == '0) ||
           (nxt.first_seen && (r_start >= {1'b0, nxt.first_start})))) begin
        nxt.second_seen  = 1'b1;
        nxt.second_start = wtpsm_pkg::IDX_W'(r_start);
      end
    end else begin
      nxt.pos = wtpsm_pkg::POS_W'(wtpsm_pkg::MAX_TEXT + 1);
    end
  end

  assign overflow = nxt.pos > wtpsm_pkg::POS_W'(wtpsm_pkg::MAX_TEXT);

  always_comb begin
    res_o = '0;
    res_o.too_long = overflow;
    if (!overflow) begin
      if ((ql == '0) && (rl == '0)) begin
        res_o.found = 1'b0;
      end else if (ql == '0) begin
        res_o.found       = nxt.second_seen;
        res_o.match_index = nxt.second_start;
      end else if (rl == '0) begin
        res_o.found       = nxt.first_seen;
        res_o.match_index = nxt.first_start;
      end else begin
        res_o.found       = nxt.first_seen && nxt.second_seen;
        res_o.match_index = nxt.first_start;
      end
    end
    if (!res_o.found) begin
      res_o.match_index = '0;
    end
  end

  // end of text returns the stream context to its reset value
  assign ctx_o = last_byte_i ? '0 : nxt;

endmodule

/* rtl/wildcard_two_part_string_match.sv */
// ----------------------------------------------------------------------------
// wildcard_two_part_string_match
// Streaming matcher for the pattern Q*R with Q and R of up to eight bytes.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------------
//   text     | in        | in_valid_i/in_ready_o | text_byte_i, last_byte_i
//   result   | out       | out_valid_o/out_ready_i | found_o, match_index_o, too_long_o
//   config   | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// One byte per cycle while in_ready_o is high. The stream context lives in
// a one-entry RAM with a registered read; the write of one byte is forwarded
// to the next byte. The result register loads on the edge that takes the
// last byte. Reset needs no clearing pass: a valid bit makes the unwritten
// entry read as zero. in_ready_o drops only while a result waits to be taken.
// ----------------------------------------------------------------------------
module wildcard_two_part_string_match (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [wtpsm_pkg::BYTE_W-1:0]        text_byte_i,
  input  logic                                last_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                found_o,
  output logic [wtpsm_pkg::IDX_W-1:0]         match_index_o,
  output logic                                too_long_o,
  input  logic                                cfg_we_i,
  input  logic [wtpsm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wtpsm_pkg::PAT_W-1:0]         cfg_data_i
);

  wtpsm_pkg::cfg_t cfg_q;
  wtpsm_pkg::ctx_t ctx_mem [1];
  wtpsm_pkg::ctx_t rd_q;
  wtpsm_pkg::ctx_t fwd_data_q;
  logic            fwd_q;
  logic            ctx_valid_q;
  wtpsm_pkg::ctx_t ctx_cur;
  wtpsm_pkg::ctx_t ctx_next;
  wtpsm_pkg::res_t res_next;
  wtpsm_pkg::res_t res_q;
  logic            out_valid_q;
  logic            out_valid_d;
  logic            in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wtpsm_pkg::CFG_Q_PATTERN: cfg_q.q_pattern <= cfg_data_i;
        wtpsm_pkg::CFG_Q_LENGTH:  cfg_q.q_length  <= cfg_data_i[wtpsm_pkg::LEN_W-1:0];
        wtpsm_pkg::CFG_R_PATTERN: cfg_q.r_pattern <= cfg_data_i;
        wtpsm_pkg::CFG_R_LENGTH:  cfg_q.r_length  <= cfg_data_i[wtpsm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // context RAM: read every cycle, written back on each byte transfer
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ctx_mem[0] <= ctx_next;
    end
    rd_q <= ctx_mem[0];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fwd_data_q <= ctx_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q       <= 1'b0;
      ctx_valid_q <= 1'b0;
    end else begin
      fwd_q <= in_fire;
      if (in_fire) begin
        ctx_valid_q <= 1'b1;
      end
    end
  end

  // just after a write the registered RAM read is stale: take the forwarded copy then
  always_comb begin
    if (fwd_q) begin
      ctx_cur = fwd_data_q;
    end else if (ctx_valid_q) begin
      ctx_cur = rd_q;
    end else begin
      ctx_cur = '0;
    end
  end

  wtpsm_scan u_scan (
    .ctx_i       (ctx_cur),
    .cfg_i       (cfg_q),
    .text_byte_i (text_byte_i),
    .last_byte_i (last_byte_i),
    .ctx_o       (ctx_next),
    .res_o       (res_next)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire && last_byte_i) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_byte_i) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = res_q.found;
  assign match_index_o = res_q.match_index;
  assign too_long_o    = res_q.too_long;

`ifndef SYNTHESIS
  // a byte without the last mark never produces a result
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !last_byte_i) |=> (out_valid_o == $past(out_valid_o && !out_ready_i)))
    else $error("result appeared for a byte that was not last");

  // an overlong text never reports a match
  a_overflow_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && too_long_o) |-> (!found_o && (match_index_o == '0)))
    else $error("too_long result carries a match");

  // the context written after the last byte is cleared
  a_ctx_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_byte_i) |=> (fwd_q && (fwd_data_q == '0)))
    else $error("stream context not cleared at end of text");

  // no match index without a match
  a_index_needs_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (match_index_o == '0))
    else $error("match index set without a match");
`endif

endmodule
